/* design/rgbhsb_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsb_pkg: shared types and constants for the RGB to HSB converter
// Component widths, fraction widths, divider depth and stage words.
// ----------------------------------------------------------------------------
package rgbhsb_pkg;

    localparam int COMP_W     = 8;   // one color component
    localparam int HUE_W      = 16;  // Q0.16 hue
    localparam int FRAC_W     = 17;  // saturation and brightness, 65536 = 1.0
    localparam int QUO_W      = 18;  // one integer bit and 17 fraction bits
    localparam int DIV_STEPS  = QUO_W;
    localparam int HDEN_W     = 11;  // 6 * d, at most 1530
    localparam int REM_W      = 12;  // doubled partial remainder

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // max, min, winning component and the signed component difference
    typedef struct packed {
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] mn;
        t_sector           sector;
        logic signed [8:0] diff;
    } t_front;

    // two divisions in flight side by side, brightness riding along
    typedef struct packed {
        logic [REM_W-1:0]  hue_rem;
        logic [HDEN_W-1:0] hue_den;
        logic [QUO_W-1:0]  hue_q;
        logic [REM_W-1:0]  sat_rem;
        logic [COMP_W-1:0] sat_den;
        logic [QUO_W-1:0]  sat_q;
        logic [FRAC_W-1:0] bri;
    } t_div_word;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] bri;
    } t_result;

    // round(mx * 65536 / 255): 65536/255 = 257 + 1/255, and mx/255 rounds
    // to one exactly when mx >= 128
    function automatic logic [FRAC_W-1:0] bri_of(input logic [COMP_W-1:0] mx);
        logic [FRAC_W-1:0] base;
        base = {1'b0, mx, mx};
        return base + {{(FRAC_W-1){1'b0}}, mx[COMP_W-1]};
    endfunction

endpackage

/* design/rgb_to_hsb_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsb_converter: 8-bit RGB pixel to hue, saturation and brightness
// Pipelined conversion with a one-bit-per-stage restoring divider pair.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+---------------------------------
//   pixel   | in        | i_valid / o_ready   | i_red, i_green, i_blue (8b each)
//   hsb     | out       | o_valid / i_ready   | o_hue (16b), o_saturation (17b),
//           |           |                     | o_brightness (17b)
//
// One pixel enters per clock while o_ready is high; each word passes two front
// stages, 18 divider stages (one quotient bit each) and the output register
// before o_valid. Synchronous active-low reset clears every valid bit.
// A stalled output parks one word in a skid register; o_ready drops only while
// that skid register is full, and the whole pipeline holds with it.
// ----------------------------------------------------------------------------
module rgb_to_hsb_converter
    import rgbhsb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COMP_W-1:0]  i_red,
    input  logic [COMP_W-1:0]  i_green,
    input  logic [COMP_W-1:0]  i_blue,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [HUE_W-1:0]   o_hue,
    output logic [FRAC_W-1:0]  o_saturation,
    output logic [FRAC_W-1:0]  o_brightness
);

    logic      w_adv;
    t_front    n_front;
    t_front    r_front;
    logic      r_front_vld;
    t_div_word n_s2;
    t_div_word r_s2;
    logic      r_s2_vld;
    t_div_word r_dv     [DIV_STEPS];
    logic      r_dv_vld [DIV_STEPS];
    t_div_word n_dv     [DIV_STEPS];
    t_result   w_res;
    t_result   r_out;
    logic      r_out_vld;
    t_result   r_skid;
    logic      r_skid_vld;
    logic      w_take;

    // the pipeline moves whenever the skid register is free
    assign w_adv   = !r_skid_vld;
    assign o_ready = w_adv;
    assign w_take  = !r_out_vld || i_ready;

    // ---------------- stage 1: max, min, sector, difference ----------------
    always_comb begin
        n_front = '0;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_front.sector = SEC_RED;
            n_front.mx     = i_red;
            n_front.diff   = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_front.sector = SEC_GREEN;
            n_front.mx     = i_green;
            n_front.diff   = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_front.sector = SEC_BLUE;
            n_front.mx     = i_blue;
            n_front.diff   = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            n_front.mn = i_red;
        end else if (i_green <= i_blue) begin
            n_front.mn = i_green;
        end else begin
            n_front.mn = i_blue;
        end
    end

    // ---------------- stage 2: hue numerator, denominators ----------------
    logic [COMP_W-1:0]  w_d;
    logic [HDEN_W-1:0]  w_d6;
    logic signed [11:0] w_off;
    logic signed [11:0] w_n;

    always_comb begin
        w_d  = r_front.mx - r_front.mn;
        w_d6 = ({3'b000, w_d} << 2) + ({3'b000, w_d} << 1);
        case (r_front.sector)
            SEC_RED:   w_off = '0;
            SEC_GREEN: w_off = {3'b000, w_d, 1'b0};
            SEC_BLUE:  w_off = {2'b00, w_d, 2'b00};
            default:   w_off = '0;
        endcase
        w_n = w_off + {{3{r_front.diff[8]}}, r_front.diff};
        if (w_n[11]) begin
            w_n = w_n + {1'b0, w_d6};
        end
        n_s2         = '0;
        n_s2.hue_rem = {1'b0, w_n[HDEN_W-1:0]};
        // a zero denominator only comes with a zero numerator: divide by one
        n_s2.hue_den = (w_d == '0) ? HDEN_W'(1) : w_d6;
        n_s2.sat_rem = {4'b0000, w_d};
        n_s2.sat_den = (r_front.mx == '0) ? COMP_W'(1) : r_front.mx;
        n_s2.bri     = bri_of(r_front.mx);
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        t_div_word        w_src;
        logic [REM_W-1:0] w_hue_t;
        logic [REM_W-1:0] w_sat_t;
        logic             w_hue_ge;
        logic             w_sat_ge;

        if (k == 0) begin : g_first
            assign w_src   = r_s2;
            assign w_hue_t = w_src.hue_rem;
            assign w_sat_t = w_src.sat_rem;
        end else begin : g_next
            assign w_src   = r_dv[k-1];
            assign w_hue_t = {w_src.hue_rem[REM_W-2:0], 1'b0};
            assign w_sat_t = {w_src.sat_rem[REM_W-2:0], 1'b0};
        end

        always_comb begin
            w_hue_ge        = w_hue_t >= {1'b0, w_src.hue_den};
            w_sat_ge        = w_sat_t >= {4'b0000, w_src.sat_den};
            n_dv[k]         = w_src;
            n_dv[k].hue_rem = w_hue_ge ? w_hue_t - {1'b0, w_src.hue_den} : w_hue_t;
            n_dv[k].sat_rem = w_sat_ge ? w_sat_t - {4'b0000, w_src.sat_den} : w_sat_t;
            n_dv[k].hue_q   = {w_src.hue_q[QUO_W-2:0], w_hue_ge};
            n_dv[k].sat_q   = {w_src.sat_q[QUO_W-2:0], w_sat_ge};
        end
    end

    // ---------------- rounding: half up from one extra quotient bit ----------------
    logic [QUO_W:0] w_hue_inc;
    logic [QUO_W:0] w_sat_inc;

    always_comb begin
        w_hue_inc = {1'b0, r_dv[DIV_STEPS-1].hue_q} + (QUO_W+1)'(1);
        w_sat_inc = {1'b0, r_dv[DIV_STEPS-1].sat_q} + (QUO_W+1)'(1);
        // a hue that rounds to a full turn wraps to zero
        w_res.hue = (w_hue_inc[QUO_W:HUE_W+1] != '0) ? '0 : w_hue_inc[HUE_W:1];
        w_res.sat = w_sat_inc[FRAC_W:1];
        w_res.bri = r_dv[DIV_STEPS-1].bri;
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= 1'b0;
            r_s2_vld    <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
            r_out_vld   <= 1'b0;
            r_skid_vld  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_front_vld <= i_valid;
                r_s2_vld    <= r_front_vld;
                r_dv_vld[0] <= r_s2_vld;
                for (int k = 1; k < DIV_STEPS; k++) begin
                    r_dv_vld[k] <= r_dv_vld[k-1];
                end
            end
            if (w_take) begin
                // drain the skid word first; the pipeline held this cycle
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld  <= r_dv_vld[DIV_STEPS-1];
                end
            end else if (w_adv && r_dv_vld[DIV_STEPS-1]) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_front <= n_front;
            r_s2    <= n_s2;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
        if (w_take) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (w_adv) begin
            r_skid <= w_res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_hue        = r_out.hue;
    assign o_saturation = r_out.sat;
    assign o_brightness = r_out.bri;

endmodule

/* design/rgbhsb_checker.sv */
// ----------------------------------------------------------------------------
// rgbhsb_checker: port-level checks for the RGB to HSB converter
// Watches the output channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module rgbhsb_checker
    import rgbhsb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [HUE_W-1:0]   o_hue,
    input logic [FRAC_W-1:0]  o_saturation,
    input logic [FRAC_W-1:0]  o_brightness
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hue)
            && $stable(o_saturation) && $stable(o_brightness))
        else $error("output word changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // fractions never exceed one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_saturation <= FRAC_W'(65536) && o_brightness <= FRAC_W'(65536))
        else $error("fraction above one");

    // gray or black pixels carry no hue
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation == '0 |-> o_hue == '0)
        else $error("hue nonzero on a gray pixel");

    // a black pixel has no saturation
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == '0 |-> o_saturation == '0)
        else $error("saturation nonzero on a black pixel");

endmodule

bind rgb_to_hsb_converter rgbhsb_checker u_rgbhsb_checker (.*);
